// ----- rtl/xtea_pkg.sv -----
// shared constants, types and the round mixing function of the xtea cipher unit
package xtea_pkg;

  // default number of feistel cycles
  localparam int XTEA_ROUNDS = 32;

  // round sum increment
  localparam logic [31:0] DELTA = 32'h9E37_79B9;

  // key register file
  localparam int KEY_WORDS = 4;
  localparam int KEY_IDX_W = 2;
  localparam int WORD_W    = 32;

  // configuration register indexes
  localparam logic [KEY_IDX_W-1:0] KEY_WORD_0 = 2'd0;
  localparam logic [KEY_IDX_W-1:0] KEY_WORD_1 = 2'd1;
  localparam logic [KEY_IDX_W-1:0] KEY_WORD_2 = 2'd2;
  localparam logic [KEY_IDX_W-1:0] KEY_WORD_3 = 2'd3;

  typedef logic [KEY_WORDS-1:0][WORD_W-1:0] key_t;

  // payload carried down the pipeline with each item
  typedef struct packed {
    logic              kind;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
  } half_t;

  // mixing function of one half-round
  function automatic logic [WORD_W-1:0] mix(input logic [WORD_W-1:0] w,
                                            input logic [WORD_W-1:0] s,
                                            input logic [WORD_W-1:0] k);
    logic [WORD_W-1:0] f;
    f = ((w << 4) ^ (w >> 5)) + w;
    return f ^ (s + k);
  endfunction

endpackage

// ----- rtl/xtea_half_round.sv -----
// one registered half-round stage of the xtea pipeline
module xtea_half_round import xtea_pkg::*; #(
  parameter int ROUNDS = XTEA_ROUNDS,
  parameter int STEP   = 0
) (
  input  logic  clk,
  input  logic  rst,
  input  key_t  key,
  input  logic  in_valid,
  input  half_t in_data,
  output logic  out_valid,
  output half_t out_data
);

  // fixed round sums and key picks of this stage for both directions
  localparam int          Round    = STEP / 2;
  localparam bit          Odd      = (STEP % 2) == 1;
  localparam int          EncCount = Round + (Odd ? 1 : 0);
  localparam int          DecCount = ROUNDS - Round - (Odd ? 1 : 0);
  localparam logic [63:0] EncWide  = 64'(DELTA) * 64'(EncCount);
  localparam logic [63:0] DecWide  = 64'(DELTA) * 64'(DecCount);
  localparam logic [31:0] SumEnc   = EncWide[31:0];
  localparam logic [31:0] SumDec   = DecWide[31:0];
  localparam logic [KEY_IDX_W-1:0] KeyEnc = Odd ? SumEnc[12:11] : SumEnc[1:0];
  localparam logic [KEY_IDX_W-1:0] KeyDec = Odd ? SumDec[1:0] : SumDec[12:11];

  logic              upd_a;
  logic [WORD_W-1:0] src;
  logic [WORD_W-1:0] dst;
  logic [WORD_W-1:0] sum;
  logic [WORD_W-1:0] kw;
  logic [WORD_W-1:0] m;
  logic [WORD_W-1:0] res;
  half_t             data_next;

  // encrypt updates a on even steps, decrypt updates a on odd steps
  always_comb begin
    upd_a = Odd ? in_data.kind : !in_data.kind;
    src   = upd_a ? in_data.b : in_data.a;
    dst   = upd_a ? in_data.a : in_data.b;
    sum   = in_data.kind ? SumDec : SumEnc;
    kw    = key[in_data.kind ? KeyDec : KeyEnc];
    m     = mix(src, sum, kw);
    res   = in_data.kind ? (dst - m) : (dst + m);
    data_next      = in_data;
    data_next.a    = upd_a ? res : in_data.a;
    data_next.b    = upd_a ? in_data.b : res;
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  // payload register
  always_ff @(posedge clk) begin
    if (in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

// ----- rtl/xtea_block_cipher_unit.sv -----
// xtea block cipher unit: 64-bit blocks, 128-bit key, one item per clock
//
// Takes one 64-bit block per cycle whenever start is high (busy is always low),
// encrypting when kind is 0 and decrypting when kind is 1 under the key held in
// key words 0..3. The pipeline has one register stage per half-round, 2*ROUNDS
// stages in all, so each result appears on block_out with done high once its
// item has passed through every stage, for one cycle only; the receiver must
// take it then. Items are independent and keep their order. Key words are
// written through wr_en, wr_index and wr_data and should only change while no
// item is in flight.
module xtea_block_cipher_unit import xtea_pkg::*; #(
  parameter int ROUNDS = XTEA_ROUNDS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic                 kind,
  input  logic [63:0]          block_in,
  output logic                 done,
  output logic [63:0]          block_out,
  input  logic                 wr_en,
  input  logic [KEY_IDX_W-1:0] wr_index,
  input  logic [WORD_W-1:0]    wr_data
);

  localparam int Stages = 2 * ROUNDS;

  key_t  key;
  logic  accept;
  logic  valid [Stages+1];
  half_t data  [Stages+1];

  // key registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (wr_en) begin
      case (wr_index)
        KEY_WORD_0: key[0] <= wr_data;
        KEY_WORD_1: key[1] <= wr_data;
        KEY_WORD_2: key[2] <= wr_data;
        KEY_WORD_3: key[3] <= wr_data;
        default:    key    <= key;
      endcase
    end
  end

  // pipeline never stalls, so an item is taken on every start
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign valid[0]     = accept;
  assign data[0].kind = kind;
  assign data[0].a    = block_in[63:32];
  assign data[0].b    = block_in[31:0];

  // half-round stage chain
  for (genvar i = 0; i < Stages; i++) begin : g_stage
    xtea_half_round #(
      .ROUNDS (ROUNDS),
      .STEP   (i)
    ) u_half (
      .clk       (clk),
      .rst       (rst),
      .key       (key),
      .in_valid  (valid[i]),
      .in_data   (data[i]),
      .out_valid (valid[i+1]),
      .out_data  (data[i+1])
    );
  end

  // last stage register drives the result
  assign done      = valid[Stages];
  assign block_out = {data[Stages].a, data[Stages].b};

  // every result comes from an item taken at the input of the stage chain
  assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, Stages))
    else $error("result without an item taken 2*ROUNDS cycles earlier");

  // every item taken yields a result once it has passed through every stage
  assert property (@(posedge clk) disable iff (rst)
    accept |-> ##Stages done)
    else $error("item taken but no result after 2*ROUNDS cycles");

  // the direction bit travels unchanged to the end of the pipeline
  assert property (@(posedge clk) disable iff (rst)
    done |-> (data[Stages].kind == $past(kind, Stages)))
    else $error("direction bit changed inside the pipeline");

endmodule
